// ===== rtl/ured_pkg.sv =====
// shared types and constants of the usb receive deframer
// no dependencies; imported by every module in rtl
`default_nettype none

package ured_pkg;

	// header length field width and position of its complement
	localparam int LEN_BITS  = 11;
	localparam int CPL_SHIFT = 16;
	// padded length counter, one bit wider than the length
	localparam int CNT_W     = LEN_BITS + 1;
	localparam int BYTE_W    = 8;
	localparam int HDR_W     = 24;
	localparam int FLEN_W    = 11;
	localparam int STAT_W    = 3;
	localparam int MAXLEN_W  = 12;

	localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = MAXLEN_W'(1536);

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_DISCARD = 3'b100
	} phase_t;

	typedef enum logic [STAT_W-1:0] {
		ST_PAYLOAD   = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_MISMATCH  = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_TRUNCATED = 3'd4
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              transfer_end;
	} item_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] payload_byte;
		logic              frame_end;
		logic [FLEN_W-1:0] frame_length;
		status_t           rx_status;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/ured_in_stage.sv =====
// input register of the deframer: holds one accepted word
// depends on ured_pkg
`default_nettype none

module ured_in_stage
	import ured_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [BYTE_W-1:0] s_rx_byte,
	input  wire logic              s_last,
	input  wire logic              advance,
	output logic                   valid_s1,
	output item_t                  item_s1
);

	// the held word moves on whenever the result side can take it
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.rx_byte      <= s_rx_byte;
			item_s1.transfer_end <= s_last;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ured_parser.sv =====
// header / payload / discard parser with its state registers
// depends on ured_pkg
`default_nettype none

module ured_parser
	import ured_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  item_t                    item,
	input  wire logic [MAXLEN_W-1:0] max_len,
	output res_t                     res
);

	phase_t              phase_q, phase_d;
	logic [1:0]          hdr_cnt_q, hdr_cnt_d;
	logic [HDR_W-1:0]    hdr_q, hdr_d;
	logic [CNT_W-1:0]    left_q, left_d;
	logic [LEN_BITS-1:0] held_q, held_d;

	logic [31:0]         word;
	logic [LEN_BITS-1:0] len;
	logic [LEN_BITS-1:0] cpl;
	logic [CNT_W-1:0]    padded;
	logic                odd;
	logic                fail;
	logic                fail_last;
	logic [LEN_BITS-1:0] fail_len;
	status_t             fail_st;

	assign word   = {item.rx_byte, hdr_q};
	assign len    = word[LEN_BITS-1:0];
	assign cpl    = ~word[CPL_SHIFT +: LEN_BITS];
	assign padded = {1'b0, len} + CNT_W'(len[0]);
	assign odd    = held_q[0];

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		hdr_d     = hdr_q;
		left_d    = left_q;
		held_d    = held_q;
		fail      = 1'b0;
		fail_last = 1'b1;
		fail_len  = '0;
		fail_st   = ST_TRUNCATED;
		res       = '{valid: 1'b0, payload_byte: '0, frame_end: 1'b0,
			frame_length: '0, rx_status: ST_PAYLOAD};

		unique case (phase_q)
			PH_DISCARD: begin
				if (item.transfer_end) begin
					phase_d   = PH_HEADER;
					hdr_cnt_d = '0;
					hdr_d     = '0;
				end
			end
			PH_PAYLOAD: begin
				if (left_q <= CNT_W'(1)) begin
					// last byte of the padded payload; pad byte gives nothing
					phase_d   = PH_HEADER;
					hdr_cnt_d = '0;
					hdr_d     = '0;
					left_d    = '0;
					if (!odd) begin
						res.valid        = 1'b1;
						res.payload_byte = item.rx_byte;
						res.frame_end    = 1'b1;
						res.frame_length = FLEN_W'(held_q);
					end
				end else if (item.transfer_end) begin
					fail     = 1'b1;
					fail_len = held_q;
				end else begin
					left_d           = left_q - CNT_W'(1);
					res.valid        = 1'b1;
					res.payload_byte = item.rx_byte;
					res.frame_end    = (left_q == CNT_W'(2)) && odd;
					res.frame_length = FLEN_W'(held_q);
				end
			end
			default: begin
				phase_d = PH_HEADER;
				if (hdr_cnt_q != 2'd3) begin
					hdr_d[{hdr_cnt_q, 3'b000} +: BYTE_W] = item.rx_byte;
					hdr_cnt_d = hdr_cnt_q + 2'd1;
					if (item.transfer_end) begin
						fail = 1'b1;
					end
				end else begin
					hdr_cnt_d = '0;
					hdr_d     = '0;
					priority if (len != cpl) begin
						fail      = 1'b1;
						fail_last = item.transfer_end;
						fail_len  = len;
						fail_st   = ST_MISMATCH;
					end else if (padded > max_len) begin
						fail      = 1'b1;
						fail_last = item.transfer_end;
						fail_len  = len;
						fail_st   = ST_TOO_LARGE;
					end else if (len == '0) begin
						held_d        = len;
						left_d        = '0;
						res.valid     = 1'b1;
						res.frame_end = 1'b1;
						res.rx_status = ST_EMPTY;
					end else if (item.transfer_end) begin
						held_d   = len;
						fail     = 1'b1;
						fail_len = len;
					end else begin
						held_d  = len;
						left_d  = padded;
						phase_d = PH_PAYLOAD;
					end
				end
			end
		endcase

		// error result: drop the rest of the transfer unless it ends here
		if (fail) begin
			phase_d          = fail_last ? PH_HEADER : PH_DISCARD;
			hdr_cnt_d        = '0;
			hdr_d            = '0;
			left_d           = '0;
			held_d           = fail_len;
			res.valid        = 1'b1;
			res.payload_byte = '0;
			res.frame_end    = 1'b1;
			res.frame_length = FLEN_W'(fail_len);
			res.rx_status    = fail_st;
		end

		if (!fire) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			hdr_q     <= '0;
			left_q    <= '0;
			held_q    <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			hdr_q     <= hdr_d;
			left_q    <= left_d;
			held_q    <= held_d;
		end
	end

	a_payload_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> left_q != '0)
		else $error("payload phase with no bytes left");

endmodule

`default_nettype wire

// ===== rtl/ured_out_stage.sv =====
// result register of the deframer, drives the master stream side
// depends on ured_pkg
`default_nettype none

module ured_out_stage
	import ured_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic fire,
	input  res_t      res,
	output logic      advance,
	input  wire logic m_tready,
	output logic      m_tvalid,
	output res_t      res_q
);

	assign advance = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (fire && res.valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/usb_eth_rx_deframer.sv =====
// top level of the usb bulk receive deframer
// depends on ured_pkg, ured_in_stage, ured_parser, ured_out_stage
`default_nettype none

// Splits the byte stream of usb bulk receive transfers into ethernet frames.
// Each frame opens with a 4-byte little-endian header: bits 10:0 give the
// payload length and bits 26:16 must hold its complement. The payload
// follows, padded to an even size; payload words carry the frame length and
// tlast on the last real byte, the pad byte is dropped. An empty frame gives
// one status word. A bad complement, a padded length above max_frame_len or
// a transfer (tlast on the input) that ends inside a frame gives one error
// word, and the rest of that transfer is dropped. The input takes one word per
// clock while m_tready is high; a word goes through an input register, the
// parser and the result register before its result appears on the master side.
// While a result word waits, the input takes one more word into its empty
// register and then stalls; s_tready follows m_tready combinationally.
// max_frame_len resets to 1536 and may only be written while the block is idle.
module usb_eth_rx_deframer
	import ured_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration: max_frame_len
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [MAXLEN_W-1:0] cfg_data,
	// input stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // [7:0] rx_byte
	input  wire logic                s_tlast,   // transfer_end
	// result stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [23:0]              m_tdata,   // [7:0] payload_byte, [18:8] frame_length, rest 0
	output logic                     m_tlast,   // frame_end
	output logic [STAT_W-1:0]        m_tuser    // rx_status
);

	logic [MAXLEN_W-1:0] max_len_q;
	logic                valid_s1;
	item_t               item_s1;
	logic                advance;
	logic                fire;
	res_t                res;
	res_t                res_q;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	ured_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_rx_byte (s_tdata),
		.s_last    (s_tlast),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	// a held word is parsed in the cycle the result register can take it
	assign fire = valid_s1 && advance;

	ured_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.max_len (max_len_q),
		.res     (res)
	);

	ured_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.res      (res),
		.advance  (advance),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.res_q    (res_q)
	);

	// pack the result word
	assign m_tdata = {5'b00000, res_q.frame_length, res_q.payload_byte};
	assign m_tlast = res_q.frame_end;
	assign m_tuser = res_q.rx_status;

	// any status word closes its frame
	a_status_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_PAYLOAD) |-> m_tlast)
		else $error("status word without frame end");

	// an empty frame reports length zero and no data
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata == '0))
		else $error("empty frame word carries data");

	// input only stalls behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	// a new result is loaded only when the register is free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

endmodule

`default_nettype wire
